FILE: hw/rtl/tmv_pkg.sv
// Shared types and constants for the Toeplitz matrix-vector multiplier.
package tmv_pkg;

    localparam int MAX_ROWS_DEF  = 32;
    localparam int MAX_COLS_DEF  = 32;
    localparam int WORD_BITS_DEF = 32;

    // Widest word the design supports; used to widen ports before trimming.
    localparam int MAX_WORD_BITS = 64;

    typedef enum logic [1:0] {
        OP_LOAD_DIAG = 2'd0,
        OP_LOAD_VEC  = 2'd1,
        OP_MULTIPLY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_MODULUS   = 2'd0,
        CFG_ROW_COUNT = 2'd1,
        CFG_COL_COUNT = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_RED,
        S_MUL_READ,
        S_MUL_RED_GO,
        S_MUL_RED,
        S_MUL_MUL,
        S_ROW_OUT
    } t_state;

    // Status of the bit-serial modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

FILE: hw/rtl/tmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmv_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tmv_modmul.sv
// Bit-serial modular multiplier: a*b mod n, one bit of b per cycle, MSB first.
module tmv_modmul #(
    parameter int WORD_BITS = tmv_pkg::WORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [WORD_BITS-1:0]    i_a,
    input  logic [WORD_BITS-1:0]    i_b,
    input  logic [WORD_BITS-1:0]    i_n,
    output logic [WORD_BITS-1:0]    o_result,
    output tmv_pkg::t_mm_status     o_status
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W+1:0]  sum;
    logic [W+1:0]  n1;
    logic [W+1:0]  n2;
    logic [W-1:0]  n_acc;

    // Doubling plus optional addend stays below 3n, so one of three
    // candidates (s, s-n, s-2n) is the reduced value.
    always_comb begin
        n1    = (W + 2)'(i_n);
        n2    = n1 << 1;
        sum   = ((W + 2)'(r_acc) << 1) + (r_b[W-1] ? (W + 2)'(r_a) : '0);
        if (sum >= n2) begin
            n_acc = W'(sum - n2);
        end else if (sum >= n1) begin
            n_acc = W'(sum - n1);
        end else begin
            n_acc = W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_result        = r_acc;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

FILE: hw/rtl/toeplitz_matvec_mod_n.sv
// Top level: Toeplitz matrix times vector modulo N, bit-serial datapath.
//
//   Channel   Direction  Handshake            Payload
//   --------  ---------  -------------------  ----------------------------------
//   input     in         i_valid / o_stall    i_operation, i_index, i_value
//   result    out        o_valid / i_stall    o_row_index, o_product_value,
//                                             o_last_row
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A load beat reduces its word modulo N in the bit-serial multiplier, one bit
// per cycle, and then writes it to its store. In a multiply beat every
// multiply-accumulate first reduces the diagonal word and then multiplies it
// by the vector element, each pass through the one shared multiplier. Reset
// (synchronous, active low) returns the controller to idle, clears the result
// valid flag and sets N=2, rows=1, cols=1; the stores are not cleared. A stalled
// result sits in the output register; the block takes the next input beat once
// the last row of a multiply has been placed there.
module toeplitz_matvec_mod_n #(
    parameter int MAX_ROWS  = tmv_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = tmv_pkg::MAX_COLS_DEF,
    parameter int WORD_BITS = tmv_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_index,
    input  logic [31:0] i_value,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_row_index,
    output logic [31:0] o_product_value,
    output logic        o_last_row,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int W          = WORD_BITS;
    localparam int EXT_BITS   = tmv_pkg::MAX_WORD_BITS;
    localparam int DIAG_DEPTH = MAX_ROWS + MAX_COLS - 1;
    localparam int DIAG_AW    = (DIAG_DEPTH > 1) ? $clog2(DIAG_DEPTH) : 1;
    localparam int VEC_AW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Configuration registers.
    logic [31:0] r_modulus;
    logic [5:0]  r_row_count;
    logic [5:0]  r_col_count;

    // Controller state and loop counters.
    tmv_pkg::t_state r_state;
    tmv_pkg::t_state n_state;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_row_last;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   r_col_last;
    logic [DIAG_AW-1:0] r_row_base;
    logic [DIAG_AW-1:0] r_daddr;
    logic [W-1:0]       r_sum;
    logic [W-1:0]       r_vec_word;
    logic               r_load_diag;
    logic [5:0]         r_load_addr;

    // Result register.
    logic        r_out_valid;
    logic [4:0]  r_out_row;
    logic [31:0] r_out_value;
    logic        r_out_last;

    // Word-width views of the modulus and the incoming value.
    logic [EXT_BITS-1:0] modulus_ext;
    logic [EXT_BITS-1:0] value_ext;
    logic [EXT_BITS-1:0] sum_ext;
    logic [W-1:0]        n_word;
    logic [W-1:0]        value_w;
    logic                n_small;

    // Effective run sizes from the count registers.
    logic [ROW_W-1:0]   rows_last;
    logic [COL_W-1:0]   cols_last;
    logic [DIAG_AW-1:0] diag_first;

    // Control strobes from the state machine.
    logic   accept_in;
    logic   mm_start;
    logic   run_start;
    logic   mac_done;
    logic   col_next;
    logic   row_next;
    logic   out_load;
    logic   out_free;
    logic   diag_we;
    logic   vec_we;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;

    // Multiplier and memories.
    logic [W-1:0]         mm_result;
    tmv_pkg::t_mm_status  mm_stat;
    logic [W-1:0]         diag_q;
    logic [W-1:0]         vec_q;
    logic [W-1:0]         store_word;
    logic [W:0]           acc_sum;
    logic [W-1:0]         acc_next;
    logic [W-1:0]         out_sum;

    assign modulus_ext = EXT_BITS'(r_modulus);
    assign value_ext   = EXT_BITS'(i_value);
    assign n_word      = modulus_ext[W-1:0];
    assign value_w     = value_ext[W-1:0];
    assign n_small     = (n_word < W'(2));

    // A count of zero means one; counts above the array size saturate.
    always_comb begin
        int rows_eff;
        int cols_eff;
        rows_eff = (r_row_count == 6'd0) ? 1 : int'(r_row_count);
        cols_eff = (r_col_count == 6'd0) ? 1 : int'(r_col_count);
        if (rows_eff > MAX_ROWS) begin
            rows_eff = MAX_ROWS;
        end
        if (cols_eff > MAX_COLS) begin
            cols_eff = MAX_COLS;
        end
        rows_last  = ROW_W'(rows_eff - 1);
        cols_last  = COL_W'(cols_eff - 1);
        diag_first = DIAG_AW'(cols_eff - 1);
    end

    // Running sum plus the fresh product, both already below N.
    assign acc_sum  = (W + 1)'(r_sum) + (W + 1)'(mm_result);
    assign acc_next = (acc_sum >= (W + 1)'(n_word)) ? W'(acc_sum - (W + 1)'(n_word))
                                                    : W'(acc_sum);

    // With N below two every stored word and every product is zero.
    assign store_word = n_small ? '0 : mm_result;
    assign out_sum    = n_small ? '0 : r_sum;
    assign sum_ext    = EXT_BITS'(out_sum);

    assign o_stall   = (r_state != tmv_pkg::S_IDLE);
    assign accept_in = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes.
    always_comb begin
        n_state   = r_state;
        mm_start  = 1'b0;
        mm_a      = W'(1);
        mm_b      = value_w;
        run_start = 1'b0;
        mac_done  = 1'b0;
        col_next  = 1'b0;
        row_next  = 1'b0;
        out_load  = 1'b0;
        diag_we   = 1'b0;
        vec_we    = 1'b0;
        unique case (r_state)
            tmv_pkg::S_IDLE: begin
                if (accept_in) begin
                    unique case (i_operation)
                        tmv_pkg::OP_LOAD_DIAG: begin
                            if (int'(i_index) < DIAG_DEPTH) begin
                                mm_start = 1'b1;
                                n_state  = tmv_pkg::S_LOAD_RED;
                            end
                        end
                        tmv_pkg::OP_LOAD_VEC: begin
                            if (int'(i_index) < MAX_COLS) begin
                                mm_start = 1'b1;
                                n_state  = tmv_pkg::S_LOAD_RED;
                            end
                        end
                        tmv_pkg::OP_MULTIPLY: begin
                            run_start = 1'b1;
                            n_state   = tmv_pkg::S_MUL_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tmv_pkg::S_LOAD_RED: begin
                if (mm_stat.done) begin
                    diag_we = r_load_diag;
                    vec_we  = !r_load_diag;
                    n_state = tmv_pkg::S_IDLE;
                end
            end
            tmv_pkg::S_MUL_READ: begin
                n_state = tmv_pkg::S_MUL_RED_GO;
            end
            tmv_pkg::S_MUL_RED_GO: begin
                mm_start = 1'b1;
                mm_b     = diag_q;
                n_state  = tmv_pkg::S_MUL_RED;
            end
            tmv_pkg::S_MUL_RED: begin
                mm_a = mm_result;
                mm_b = r_vec_word;
                if (mm_stat.done) begin
                    mm_start = 1'b1;
                    n_state  = tmv_pkg::S_MUL_MUL;
                end
            end
            tmv_pkg::S_MUL_MUL: begin
                if (mm_stat.done) begin
                    mac_done = 1'b1;
                    if (r_col == r_col_last) begin
                        n_state = tmv_pkg::S_ROW_OUT;
                    end else begin
                        col_next = 1'b1;
                        n_state  = tmv_pkg::S_MUL_READ;
                    end
                end
            end
            tmv_pkg::S_ROW_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_row == r_row_last) begin
                        n_state = tmv_pkg::S_IDLE;
                    end else begin
                        row_next = 1'b1;
                        n_state  = tmv_pkg::S_MUL_READ;
                    end
                end
            end
            default: begin
                n_state = tmv_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration writes; the user sends them only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= 32'd2;
            r_row_count <= 6'd1;
            r_col_count <= 6'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tmv_pkg::CFG_MODULUS:   r_modulus   <= i_cfg_data;
                tmv_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[5:0];
                tmv_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Loop counters, accumulator and load bookkeeping.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_load_diag <= (i_operation == tmv_pkg::OP_LOAD_DIAG);
            r_load_addr <= i_index;
        end
        if (run_start) begin
            r_row      <= '0;
            r_col      <= '0;
            r_row_last <= rows_last;
            r_col_last <= cols_last;
            r_row_base <= diag_first;
            r_daddr    <= diag_first;
            r_sum      <= '0;
        end
        if (r_state == tmv_pkg::S_MUL_RED_GO) begin
            r_vec_word <= vec_q;
        end
        if (mac_done) begin
            r_sum <= acc_next;
        end
        if (col_next) begin
            r_col   <= r_col + COL_W'(1);
            r_daddr <= r_daddr - DIAG_AW'(1);
        end
        if (row_next) begin
            // Entry (i,j) is diagonal word cols-1+i-j, so each new row
            // starts one word further along.
            r_row      <= r_row + ROW_W'(1);
            r_col      <= '0;
            r_row_base <= r_row_base + DIAG_AW'(1);
            r_daddr    <= r_row_base + DIAG_AW'(1);
            r_sum      <= '0;
        end
    end

    // Result register: refilled when empty or when its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row   <= 5'(r_row);
            r_out_value <= sum_ext[31:0];
            r_out_last  <= (r_row == r_row_last);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_row_index     = r_out_row;
    assign o_product_value = r_out_value;
    assign o_last_row      = r_out_last;

    tmv_modmul #(
        .WORD_BITS (W)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_n      (n_word),
        .o_result (mm_result),
        .o_status (mm_stat)
    );

    tmv_ram #(
        .WIDTH (W),
        .DEPTH (DIAG_DEPTH)
    ) u_diag_ram (
        .i_clk   (i_clk),
        .i_we    (diag_we),
        .i_waddr (DIAG_AW'(r_load_addr)),
        .i_wdata (store_word),
        .i_raddr (r_daddr),
        .o_rdata (diag_q)
    );

    tmv_ram #(
        .WIDTH (W),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (VEC_AW'(r_load_addr)),
        .i_wdata (store_word),
        .i_raddr (VEC_AW'(r_col)),
        .o_rdata (vec_q)
    );

    // The multiplier is never left running when the controller goes idle.
    a_idle_mm_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmv_pkg::S_IDLE) |-> !mm_stat.busy)
        else $error("multiplier busy while controller idle");

    // A finished pass only ever lands in a state that waits for it.
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_stat.done |-> (r_state == tmv_pkg::S_LOAD_RED ||
                          r_state == tmv_pkg::S_MUL_RED ||
                          r_state == tmv_pkg::S_MUL_MUL))
        else $error("multiplier done outside a waiting state");

    // In S_MUL_READ the diagonal address tracks cols-1+i-j.
    a_diag_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmv_pkg::S_MUL_READ) |-> (r_daddr + DIAG_AW'(r_col) == r_row_base))
        else $error("diagonal address out of step with column counter");

    // Counters stay inside the run that was started.
    a_run_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmv_pkg::S_MUL_READ) |-> (r_col <= r_col_last && r_row <= r_row_last))
        else $error("row or column counter beyond the run");

endmodule
